/* rtl/fsip_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsip_pkg: shared types and constants of the integer format printer
// Beat types, ASCII codes, the digit table, the sequencer's control word and
// the microprogram that drives it.
// ----------------------------------------------------------------------------
package fsip_pkg;

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [31:0] arg_value;
    } fmt_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } chr_beat_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        begin
            case (d)
                4'h0: c = 8'h30;
                4'h1: c = 8'h31;
                4'h2: c = 8'h32;
                4'h3: c = 8'h33;
                4'h4: c = 8'h34;
                4'h5: c = 8'h35;
                4'h6: c = 8'h36;
                4'h7: c = 8'h37;
                4'h8: c = 8'h38;
                4'h9: c = 8'h39;
                4'hA: c = 8'h41;
                4'hB: c = 8'h42;
                4'hC: c = 8'h43;
                4'hD: c = 8'h44;
                4'hE: c = 8'h45;
                default: c = 8'h46;
            endcase
            return c;
        end
    endfunction

    // Control and status between the sequencer and the digit unit.
    typedef struct packed {
        logic load;
        logic decimal;
        logic div;
        logic pop;
    } dctl_t;

    typedef struct packed {
        logic       decimal;
        logic       neg;
        logic       q_nz;
        logic       count_one;
        logic [7:0] top_char;
    } dstat_t;

    typedef logic [2:0] pc_t;

    localparam pc_t PC_DIV  = 3'd0;
    localparam pc_t PC_SIGN = 3'd1;
    localparam pc_t PC_ZERO = 3'd2;
    localparam pc_t PC_X    = 3'd3;
    localparam pc_t PC_POP  = 3'd4;
    localparam pc_t PC_PCT  = 3'd5;
    localparam pc_t PC_FMT  = 3'd6;
    localparam pc_t PC_LAST = PC_FMT;

    typedef enum logic [1:0] {EMIT_NEVER, EMIT_ALWAYS, EMIT_IF_NEG} emit_t;
    typedef enum logic [2:0] {SRC_FMT, SRC_PCT, SRC_MINUS, SRC_ZERO, SRC_X, SRC_DIGIT} src_t;
    typedef enum logic [1:0] {LAST_NO, LAST_YES, LAST_STACK} last_t;
    typedef enum logic [1:0] {OP_NONE, OP_DIV, OP_POP} op_t;
    typedef enum logic [1:0] {JMP_NONE, JMP_QNZ, JMP_DEC, JMP_MORE} jcond_t;

    typedef struct packed {
        emit_t  emit;
        src_t   src;
        last_t  last;
        op_t    op;
        jcond_t jcond;
        pc_t    target;
        logic   done;
    } ucode_t;

    // The microprogram. A step whose jump is not taken ends the item when
    // done is set and otherwise falls through to the next address.
    function automatic ucode_t ucode(input pc_t pc);
        ucode_t w;
        begin
            w = '{EMIT_NEVER, SRC_FMT, LAST_NO, OP_NONE, JMP_NONE, PC_DIV, 1'b1};
            case (pc)
                PC_DIV:  w = '{EMIT_NEVER, SRC_FMT, LAST_NO, OP_DIV, JMP_QNZ, PC_DIV, 1'b0};
                PC_SIGN: w = '{EMIT_IF_NEG, SRC_MINUS, LAST_NO, OP_NONE, JMP_DEC, PC_POP,
                               1'b0};
                PC_ZERO: w = '{EMIT_ALWAYS, SRC_ZERO, LAST_NO, OP_NONE, JMP_NONE, PC_DIV,
                               1'b0};
                PC_X:    w = '{EMIT_ALWAYS, SRC_X, LAST_NO, OP_NONE, JMP_NONE, PC_DIV, 1'b0};
                PC_POP:  w = '{EMIT_ALWAYS, SRC_DIGIT, LAST_STACK, OP_POP, JMP_MORE, PC_POP,
                               1'b1};
                PC_PCT:  w = '{EMIT_ALWAYS, SRC_PCT, LAST_NO, OP_NONE, JMP_NONE, PC_DIV, 1'b0};
                PC_FMT:  w = '{EMIT_ALWAYS, SRC_FMT, LAST_YES, OP_NONE, JMP_NONE, PC_DIV,
                               1'b1};
                default: w = '{EMIT_NEVER, SRC_FMT, LAST_NO, OP_NONE, JMP_NONE, PC_DIV, 1'b1};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/fsip_digit_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fsip_digit_unit: magnitude register, divide step and digit stack
// Each divide step takes one digit off the magnitude and pushes it; the
// digits then pop off most significant first.
// ----------------------------------------------------------------------------
module fsip_digit_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fsip_pkg::dctl_t ctl,
    input  wire logic [31:0]    arg,
    output fsip_pkg::dstat_t    stat
);

    logic [31:0] mag_reg, mag_next;
    logic        dec_reg, dec_next;
    logic        neg_reg, neg_next;
    logic [fsip_pkg::CNT_W-1:0] count_reg, count_next;
    logic [3:0]  digit_reg [fsip_pkg::MAX_DIGITS];

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] tenq;
    logic [3:0]  rem;
    logic        neg_in;

    always_comb
    begin
        prod = 64'(mag_reg) * 64'(fsip_pkg::RECIP_TEN);
        if (dec_reg)
        begin
            quot = 32'(prod[63:35]);
            tenq = (quot << 3) + (quot << 1);
            rem  = 4'(mag_reg - tenq);
        end
        else
        begin
            quot = mag_reg >> 4;
            tenq = 32'd0;
            rem  = mag_reg[3:0];
        end

        neg_in     = ctl.decimal & arg[31];
        mag_next   = mag_reg;
        dec_next   = dec_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        if (ctl.load)
        begin
            mag_next   = neg_in ? (32'd0 - arg) : arg;
            dec_next   = ctl.decimal;
            neg_next   = neg_in;
            count_next = '0;
        end
        else if (ctl.div)
        begin
            mag_next   = quot;
            count_next = count_reg + fsip_pkg::CNT_W'(1);
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - fsip_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dec_reg   <= 1'b0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            dec_reg   <= dec_next;
            neg_reg   <= neg_next;
        end
    end

    // The top of the stack is entry zero.
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        if (ctl.div)
        begin
            digit_reg[0] <= rem;
            for (int i = 1; i < fsip_pkg::MAX_DIGITS; i++)
            begin
                digit_reg[i] <= digit_reg[i-1];
            end
        end
        else if (ctl.pop)
        begin
            for (int i = 0; i < fsip_pkg::MAX_DIGITS - 1; i++)
            begin
                digit_reg[i] <= digit_reg[i+1];
            end
        end
    end

    assign stat.decimal   = dec_reg;
    assign stat.neg       = neg_reg;
    assign stat.q_nz      = (quot != 32'd0);
    assign stat.count_one = (count_reg == fsip_pkg::CNT_W'(1));
    assign stat.top_char  = fsip_pkg::digit_char(digit_reg[0]);

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fsip_pkg::CNT_W'(fsip_pkg::MAX_DIGITS))
        else $error("digit stack overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |-> count_reg != '0)
        else $error("pop from an empty digit stack");
`endif

endmodule
`default_nettype wire

/* rtl/format_string_integer_printer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// format_string_integer_printer: integer printf formatter
// Takes one format byte with its argument word per beat on the fmt channel
// and sends the resulting ASCII characters, one per beat, on the chr channel.
// A beat on either channel moves when valid is high and stall is low.
// last_of_run marks the final character caused by one format beat.
// Beats that print nothing (NUL, a lone percent sign) are taken every cycle.
// Any other beat holds fmt_stall high while a short microprogram runs, one
// step per cycle: one step per character for plain and percent cases; for a
// conversion one divide step per digit (n), one sign step, two prefix steps
// for hex, and one step per digit popped. For a byte that needs no
// conversion the first character is loaded into the output register by the
// first microprogram step. A step that prints waits while the output
// register holds a character that the receiver stalls. Reset clears the
// pending percent, the sequencer and the output valid flag, but not the
// output character.
// ----------------------------------------------------------------------------
module format_string_integer_printer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fmt_valid,
    output logic                     fmt_stall,
    input  wire fsip_pkg::fmt_beat_t fmt_data,
    output logic                     chr_valid,
    input  wire logic                chr_stall,
    output fsip_pkg::chr_beat_t      chr_data
);

    logic                busy_reg, busy_next;
    logic                pending_reg, pending_next;
    fsip_pkg::pc_t       pc_reg, pc_next;
    logic [7:0]          fmt_reg, fmt_next;
    logic                chr_valid_reg, chr_valid_next;
    fsip_pkg::chr_beat_t chr_data_reg, chr_data_next;

    fsip_pkg::ucode_t w;
    fsip_pkg::dctl_t  dctl;
    fsip_pkg::dstat_t dstat;

    logic       accept;
    logic       emit_req;
    logic       out_free;
    logic       step;
    logic       jump;
    logic       is_num;
    logic [7:0] emit_char;
    logic       emit_last;

    fsip_digit_unit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .arg   (fmt_data.arg_value),
        .stat  (dstat)
    );

    always_comb
    begin
        w        = fsip_pkg::ucode(pc_reg);
        accept   = fmt_valid && !busy_reg;
        out_free = !chr_valid_reg || !chr_stall;
        emit_req = (w.emit == fsip_pkg::EMIT_ALWAYS) ||
                   ((w.emit == fsip_pkg::EMIT_IF_NEG) && dstat.neg);
        step     = busy_reg && (!emit_req || out_free);

        case (w.jcond)
            fsip_pkg::JMP_QNZ:  jump = dstat.q_nz;
            fsip_pkg::JMP_DEC:  jump = dstat.decimal;
            fsip_pkg::JMP_MORE: jump = !dstat.count_one;
            default:            jump = 1'b0;
        endcase

        case (w.src)
            fsip_pkg::SRC_PCT:   emit_char = fsip_pkg::CH_PERCENT;
            fsip_pkg::SRC_MINUS: emit_char = fsip_pkg::CH_MINUS;
            fsip_pkg::SRC_ZERO:  emit_char = fsip_pkg::CH_ZERO;
            fsip_pkg::SRC_X:     emit_char = fsip_pkg::CH_X;
            fsip_pkg::SRC_DIGIT: emit_char = dstat.top_char;
            default:             emit_char = fmt_reg;
        endcase

        case (w.last)
            fsip_pkg::LAST_YES:   emit_last = 1'b1;
            fsip_pkg::LAST_STACK: emit_last = dstat.count_one;
            default:              emit_last = 1'b0;
        endcase

        is_num = (fmt_data.fmt_char == fsip_pkg::CH_D) ||
                 (fmt_data.fmt_char == fsip_pkg::CH_X) ||
                 (fmt_data.fmt_char == fsip_pkg::CH_P);

        dctl.load    = accept && pending_reg && is_num;
        dctl.decimal = (fmt_data.fmt_char == fsip_pkg::CH_D);
        dctl.div     = step && (w.op == fsip_pkg::OP_DIV);
        dctl.pop     = step && (w.op == fsip_pkg::OP_POP);

        busy_next      = busy_reg;
        pending_next   = pending_reg;
        pc_next        = pc_reg;
        fmt_next       = fmt_reg;
        chr_valid_next = chr_valid_reg && chr_stall;
        chr_data_next  = chr_data_reg;

        if (accept)
        begin
            fmt_next = fmt_data.fmt_char;
            if (fmt_data.fmt_char == fsip_pkg::CH_NUL)
            begin
                pending_next = 1'b0;
            end
            else if (!pending_reg)
            begin
                if (fmt_data.fmt_char == fsip_pkg::CH_PERCENT)
                begin
                    pending_next = 1'b1;
                end
                else
                begin
                    busy_next = 1'b1;
                    pc_next   = fsip_pkg::PC_FMT;
                end
            end
            else
            begin
                pending_next = 1'b0;
                busy_next    = 1'b1;
                if (is_num)
                begin
                    pc_next = fsip_pkg::PC_DIV;
                end
                else if (fmt_data.fmt_char == fsip_pkg::CH_PERCENT)
                begin
                    pc_next = fsip_pkg::PC_FMT;
                end
                else
                begin
                    pc_next = fsip_pkg::PC_PCT;
                end
            end
        end
        else if (step)
        begin
            if (emit_req)
            begin
                chr_valid_next             = 1'b1;
                chr_data_next.out_char     = emit_char;
                chr_data_next.last_of_run  = emit_last;
            end
            if (jump)
            begin
                pc_next = w.target;
            end
            else if (w.done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = fsip_pkg::pc_t'(pc_reg + 3'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pending_reg   <= 1'b0;
            pc_reg        <= fsip_pkg::PC_DIV;
            chr_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pending_reg   <= pending_next;
            pc_reg        <= pc_next;
            chr_valid_reg <= chr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_reg      <= fmt_next;
        chr_data_reg <= chr_data_next;
    end

    assign fmt_stall = busy_reg;
    assign chr_valid = chr_valid_reg;
    assign chr_data  = chr_data_reg;

`ifndef SYNTHESIS
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> pc_reg <= fsip_pkg::PC_LAST)
        else $error("sequencer left the program");
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> chr_valid && chr_data.last_of_run)
        else $error("item ended without a final character");
    a_conv_start: assert property (@(posedge clk) disable iff (!rst_n)
        dctl.load |=> busy_reg && pc_reg == fsip_pkg::PC_DIV)
        else $error("conversion did not start at the divide step");
`endif

endmodule
`default_nettype wire

/* tb/sv/format_string_integer_printer_tb.sv */
// ----------------------------------------------------------------------------
// format_string_integer_printer_tb: self-checking bench for the format printer
// Sends format bytes with argument words and predicts the ASCII characters
// that each byte prints, tracking the pending percent sign on its own. Every
// character beat is checked against the oldest predicted one. The run covers
// directed corner cases, a long receiver hold-off that backs up the input,
// and random format strings, with random input gaps and receiver stalls.
// ----------------------------------------------------------------------------
module format_string_integer_printer_tb;

    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_Q       = 8'h71;
    localparam logic [7:0] CH_A_UPPER = 8'h41;
    localparam int         ITEM_GOAL  = 430;
    localparam int         CYCLE_LIMIT = 1000000;

    logic                clk;
    logic                rst_n;
    logic                fmt_valid;
    logic                fmt_stall;
    fsip_pkg::fmt_beat_t fmt_data;
    logic                chr_valid;
    logic                chr_stall;
    fsip_pkg::chr_beat_t chr_data;

    fsip_pkg::chr_beat_t pending_chars[$];
    logic      pct_armed;
    int        mismatch_count;
    int        cycle_count;
    int        sent_items;
    bit        tx_steady;
    bit        hold_req;
    int        hold_cycles;

    format_string_integer_printer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_valid (fmt_valid),
        .fmt_stall (fmt_stall),
        .fmt_data  (fmt_data),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr_data  (chr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] ascii_digit(input logic [3:0] d);
        if (d < 4'd10)
            return fsip_pkg::CH_ZERO + {4'h0, d};
        return CH_A_UPPER + {4'h0, d} - 8'd10;
    endfunction

    // Works out the characters that one format byte prints and queues them.
    function automatic void render_fmt_byte(input logic [7:0] c, input logic [31:0] arg);
        logic [7:0]  txt[$];
        logic [31:0] mag;
        bit          neg;
        if (c == fsip_pkg::CH_NUL)
        begin
            pct_armed = 1'b0;
            return;
        end
        if (!pct_armed)
        begin
            if (c == fsip_pkg::CH_PERCENT)
            begin
                pct_armed = 1'b1;
                return;
            end
            txt.push_back(c);
        end
        else
        begin
            pct_armed = 1'b0;
            if (c == fsip_pkg::CH_D)
            begin
                neg = arg[31];
                mag = neg ? (32'd0 - arg) : arg;
                do
                begin
                    txt.push_front(ascii_digit(4'(mag % 32'd10)));
                    mag = mag / 32'd10;
                end
                while (mag != 32'd0);
                if (neg)
                    txt.push_front(fsip_pkg::CH_MINUS);
            end
            else if (c == fsip_pkg::CH_X || c == fsip_pkg::CH_P)
            begin
                mag = arg;
                do
                begin
                    txt.push_front(ascii_digit(mag[3:0]));
                    mag = mag >> 4;
                end
                while (mag != 32'd0);
                txt.push_front(fsip_pkg::CH_X);
                txt.push_front(fsip_pkg::CH_ZERO);
            end
            else if (c == fsip_pkg::CH_PERCENT)
                txt.push_back(fsip_pkg::CH_PERCENT);
            else
            begin
                txt.push_back(fsip_pkg::CH_PERCENT);
                txt.push_back(c);
            end
        end
        foreach (txt[i])
            pending_chars.push_back(fsip_pkg::chr_beat_t'{out_char: txt[i],
                                    last_of_run: (i == txt.size() - 1)});
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_arg();
        logic [31:0] p;
        int          r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            5: return {1'b1, 31'($urandom)};
            6:
            begin
                p = 32'd1;
                repeat ($urandom_range(1, 9)) p = p * 32'd10;
                return p + 32'($urandom_range(0, 2)) - 32'd1;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == fsip_pkg::CH_PERCENT);
        return c;
    endfunction

    task automatic send_fmt(input logic [7:0] c, input logic [31:0] arg);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            fmt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fmt_data  <= fsip_pkg::fmt_beat_t'{fmt_char: c, arg_value: arg};
        fmt_valid <= 1'b1;
        do
            @(posedge clk);
        while (fmt_stall);
        render_fmt_byte(c, arg);
        sent_items++;
    endtask

    task automatic send_conv(input logic [7:0] spec, input logic [31:0] arg);
        send_fmt(fsip_pkg::CH_PERCENT, $urandom);
        send_fmt(spec, arg);
    endtask

    task automatic test_directed();
        send_fmt(CH_A_UPPER, $urandom);
        send_fmt(8'hFF, 32'hFFFF_FFFF);
        send_fmt(8'h01, 32'h0000_0000);
        send_fmt(fsip_pkg::CH_NUL, $urandom);
        send_conv(fsip_pkg::CH_D, 32'd0);
        send_conv(fsip_pkg::CH_D, 32'h8000_0000);
        send_conv(fsip_pkg::CH_D, 32'h7FFF_FFFF);
        send_conv(fsip_pkg::CH_D, 32'hFFFF_FFFF);
        send_conv(fsip_pkg::CH_X, 32'd0);
        send_conv(fsip_pkg::CH_X, 32'hFFFF_FFFF);
        send_conv(fsip_pkg::CH_P, 32'hDEAD_BEEF);
        send_conv(fsip_pkg::CH_PERCENT, $urandom);
        send_conv(CH_S, $urandom);
        send_fmt(fsip_pkg::CH_PERCENT, $urandom);
        send_fmt(fsip_pkg::CH_NUL, $urandom);
        send_fmt(fsip_pkg::CH_D, 32'h8000_0000);
    endtask

    // The receiver stalls for a long stretch while conversions keep coming,
    // so the block fills up and has to stall its input.
    task automatic test_receiver_holdoff();
        tx_steady   = 1'b1;
        hold_cycles = 400;
        hold_req    = 1'b1;
        repeat (20) send_conv(fsip_pkg::CH_D, 32'h8000_0000 | 32'($urandom));
        tx_steady = 1'b0;
    endtask

    task automatic test_random_formats();
        int r;
        while (sent_items < ITEM_GOAL)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 8))
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                    send_fmt(plain_byte(), $urandom);
                else if (r < 85)
                begin
                    case ($urandom_range(0, 6))
                        0, 1: send_conv(fsip_pkg::CH_D, pick_arg());
                        2: send_conv(fsip_pkg::CH_X, pick_arg());
                        3: send_conv(fsip_pkg::CH_P, pick_arg());
                        4: send_conv(fsip_pkg::CH_PERCENT, $urandom);
                        5: send_conv(CH_S, $urandom);
                        default: send_conv(8'($urandom_range(0, 255)), pick_arg());
                    endcase
                end
                else
                    send_fmt(8'($urandom_range(0, 255)), $urandom);
            end
            send_fmt(fsip_pkg::CH_NUL, $urandom);
        end
        tx_steady = 1'b0;
    endtask

    initial
    begin : chr_receiver
        int r;
        int quiet_left;
        quiet_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                chr_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_req = 1'b0;
                chr_stall <= 1'b0;
            end
            else if (quiet_left > 0)
            begin
                quiet_left--;
                chr_stall <= 1'b0;
            end
            else if (r < 5)
            begin
                quiet_left = $urandom_range(20, 80);
                chr_stall <= 1'b0;
            end
            else if (r < 60)
                chr_stall <= 1'b0;
            else
            begin
                chr_stall <= 1'b1;
                repeat ((r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39))
                    @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : chr_check
        fsip_pkg::chr_beat_t want;
        if (rst_n && chr_valid && !chr_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character beat: out_char 0x%02h", chr_data.out_char);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (chr_data.out_char !== want.out_char)
                begin
                    $error("out_char: expected 0x%02h, got 0x%02h",
                           want.out_char, chr_data.out_char);
                    mismatch_count++;
                end
                if (chr_data.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, chr_data.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        fmt_valid      = 1'b0;
        fmt_data       = '0;
        chr_stall      = 1'b0;
        pct_armed      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        sent_items     = 0;
        tx_steady      = 1'b0;
        hold_req       = 1'b0;
        hold_cycles    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_receiver_holdoff();
        test_random_formats();
        fmt_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
